>>> rtl/core/bfeu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the brainfuck execute unit.
// No dependencies; imported by the core and its checker.
package bfeu_pkg;

   // Default storage sizes
   localparam int TAPE_CELLS_DEF  = 32768;
   localparam int STACK_DEPTH_DEF = 64;

   // Program address space is fixed by the 16-bit address field
   localparam int PROGRAM_WORDS = 65536;
   localparam int ADDR_W        = 16;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   // Skip-mode nesting counter
   localparam int SKIP_W = 7;
   localparam logic [SKIP_W-1:0] SKIP_DEPTH_MAX = 7'd127;

   // Command characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } err_type;

   // Request item, last field in the low bits
   typedef struct packed {
      logic              in_available;
      logic [7:0]        in_byte;
      logic [ADDR_W-1:0] instr_addr;
      logic [7:0]        instr;
   } req_type;

   // Result item, last field in the low bits
   typedef struct packed {
      logic [2:0]        pad;
      err_type           error;
      logic [ADDR_W-1:0] jump_target;
      logic              jump_taken;
      logic              in_taken;
      logic [7:0]        out_byte;
      logic              out_valid;
   } rsp_type;

endpackage

>>> rtl/core/brainfuck_execute_unit.sv
`timescale 1ns / 1ps
// Brainfuck execute unit: tape and loop-stack RAMs, pointer, skip mode.
// Depends on bfeu_pkg and bfeu_ram.
//
// Usage:
//   The fetcher sends one program character per transfer on the req_ stream,
//   together with its program address and the next input byte on offer. Each
//   item gives exactly one result on the rsp_ stream: an emitted byte, an
//   input-consumed flag, a jump request with its target, an error code, or none.
//   Throughput is one item per cycle while the receiver keeps up. The tape and
//   stack RAMs are read at the item's transfer, the item then executes in the
//   execute stage once the output register is free, and its result lands in
//   the output register. A write to the current cell or a push is forwarded
//   to the item right behind it, so dependent items run back to back.
//   After reset the tape RAM, TAPE_CELLS cells (32768 by default), is cleared
//   one cell per cycle; req_tready stays low until it ends.
//   When the receiver stalls, the result waits in the output register, one
//   more item waits in the execute stage, and then req_tready drops.
//   A jump result tells the fetcher to resume at jump_target; items already
//   sent after the ']' are still executed in order.
module brainfuck_execute_unit #(
   parameter int TAPE_CELLS  = bfeu_pkg::TAPE_CELLS_DEF,
   parameter int STACK_DEPTH = bfeu_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: instr[7:0], instr_addr[23:8], in_byte[31:24], in_available[32]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bfeu_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: out_valid[0], out_byte[8:1], in_taken[9], jump_taken[10],
   //            jump_target[26:11], error[28:27]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bfeu_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import bfeu_pkg::*;

   localparam int PTR_W  = $clog2(TAPE_CELLS);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int SIDX_W = $clog2(STACK_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(TAPE_CELLS - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(STACK_DEPTH);

   // Execute stage
   logic    s1_valid_ff;
   req_type s1_req_ff;
   logic    s1_fire;

   // Architectural state
   logic [PTR_W-1:0]  pointer_ff, pointer_in;
   logic [CNT_W-1:0]  stack_count_ff, stack_count_in;
   logic              skipping_ff, skipping_in;
   logic [SKIP_W-1:0] skip_depth_ff, skip_depth_in;

   // Tape clearing pass after reset
   logic             clear_ff;
   logic [PTR_W-1:0] clear_addr_ff;

   // Forwarding of the last tape write and the last push
   logic              tape_fwd_ff;
   logic [7:0]        tape_fwd_data_ff;
   logic              stk_fwd_ff;
   logic [ADDR_W-1:0] stk_fwd_data_ff;

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, res_in;

   // RAM ports
   logic              tape_we, exec_we;
   logic [PTR_W-1:0]  tape_waddr;
   logic [7:0]        tape_wdata, exec_wdata, tape_rdata;
   logic              push;
   logic [ADDR_W-1:0] stk_rdata;

   logic [7:0]        cur_cell;
   logic [ADDR_W-1:0] top;

   // Handshake
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clear_ff && (!s1_valid_ff || s1_fire);

   assign cur_cell = tape_fwd_ff ? tape_fwd_data_ff : tape_rdata;
   assign top      = stk_fwd_ff ? stk_fwd_data_ff : stk_rdata;

   // Execute one character
   always_comb begin
      pointer_in     = pointer_ff;
      stack_count_in = stack_count_ff;
      skipping_in    = skipping_ff;
      skip_depth_in  = skip_depth_ff;
      exec_we        = 1'b0;
      exec_wdata     = cur_cell;
      push           = 1'b0;
      res_in         = '0;
      if (s1_fire) begin
         if (skipping_ff) begin
            // Only brackets matter while skipping
            if (s1_req_ff.instr == CH_OPEN) begin
               if (skip_depth_ff != SKIP_DEPTH_MAX) begin
                  skip_depth_in = skip_depth_ff + SKIP_W'(1);
               end
            end else if (s1_req_ff.instr == CH_CLOSE) begin
               if (skip_depth_ff == '0) begin
                  skipping_in = 1'b0;
               end else begin
                  skip_depth_in = skip_depth_ff - SKIP_W'(1);
               end
            end
         end else begin
            unique case (s1_req_ff.instr)
               CH_RIGHT: begin
                  pointer_in = (pointer_ff == PTR_LAST) ? '0 : pointer_ff + PTR_W'(1);
               end
               CH_LEFT: begin
                  pointer_in = (pointer_ff == '0) ? PTR_LAST : pointer_ff - PTR_W'(1);
               end
               CH_PLUS: begin
                  exec_we    = 1'b1;
                  exec_wdata = cur_cell + 8'd1;
               end
               CH_MINUS: begin
                  exec_we    = 1'b1;
                  exec_wdata = cur_cell - 8'd1;
               end
               CH_OPEN: begin
                  if (cur_cell != 8'd0) begin
                     if (stack_count_ff == CNT_FULL) begin
                        res_in.error = ERR_OVERFLOW;
                     end else begin
                        push           = 1'b1;
                        stack_count_in = stack_count_ff + CNT_W'(1);
                     end
                  end else begin
                     skipping_in   = 1'b1;
                     skip_depth_in = '0;
                  end
               end
               CH_CLOSE: begin
                  if (stack_count_ff == '0) begin
                     res_in.error = ERR_UNDERFLOW;
                  end else if (cur_cell == 8'd0) begin
                     stack_count_in = stack_count_ff - CNT_W'(1);
                  end else begin
                     // wraps within the 16-bit program space
                     res_in.jump_taken  = 1'b1;
                     res_in.jump_target = top + ADDR_W'(1);
                  end
               end
               CH_DOT: begin
                  if (cur_cell != 8'd0) begin
                     res_in.out_valid = 1'b1;
                     res_in.out_byte  = cur_cell;
                  end
               end
               CH_COMMA: begin
                  exec_we = 1'b1;
                  if (s1_req_ff.in_available) begin
                     exec_wdata      = s1_req_ff.in_byte;
                     res_in.in_taken = 1'b1;
                  end else begin
                     exec_wdata = 8'd0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Tape write port: clearing pass or execute write at the pointer
   assign tape_we    = clear_ff || exec_we;
   assign tape_waddr = clear_ff ? clear_addr_ff : pointer_ff;
   assign tape_wdata = clear_ff ? 8'd0 : exec_wdata;

   bfeu_ram #(
      .WIDTH (8),
      .DEPTH (TAPE_CELLS)
   ) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_addr (pointer_in),
      .rd_data (tape_rdata)
   );

   // Stack read always targets the top after the current item
   bfeu_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (stack_count_ff[SIDX_W-1:0]),
      .wr_data (s1_req_ff.instr_addr),
      .rd_addr (SIDX_W'(stack_count_in - CNT_W'(1))),
      .rd_data (stk_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pointer_ff     <= '0;
         stack_count_ff <= '0;
         skipping_ff    <= 1'b0;
         skip_depth_ff  <= '0;
         clear_ff       <= 1'b1;
         clear_addr_ff  <= '0;
         tape_fwd_ff    <= 1'b0;
         stk_fwd_ff     <= 1'b0;
      end else begin
         pointer_ff     <= pointer_in;
         stack_count_ff <= stack_count_in;
         skipping_ff    <= skipping_in;
         skip_depth_ff  <= skip_depth_in;
         tape_fwd_ff    <= exec_we;
         stk_fwd_ff     <= push;

         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + PTR_W'(1);
            if (clear_addr_ff == PTR_LAST) begin
               clear_ff <= 1'b0;
            end
         end

         if (req_tvalid && req_tready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tape_fwd_data_ff <= exec_wdata;
      stk_fwd_data_ff  <= s1_req_ff.instr_addr;
      if (req_tvalid && req_tready) begin
         s1_req_ff <= req_type'(req_tdata[$bits(req_type)-1:0]);
      end
      if (s1_fire) begin
         rsp_data_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/bfeu_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old data. No dependencies.
module bfeu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bfeu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for brainfuck_execute_unit, attached by bind.
// Depends on bfeu_pkg and the top level's port list.
module bfeu_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [bfeu_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bfeu_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import bfeu_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset starts the tape clear: no transfer and no result right after it
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("transfer possible right after reset");

   // An accepted item has its result valid after the execute stage and output register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("result missing after accepted item");

   // At most one kind of outcome per result
   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp_tdata[0], rsp_tdata[9], rsp_tdata[10],
                               rsp_tdata[28:27] != 2'd0}))
      else $error("result carries more than one outcome");

   // Emitted bytes are nonzero; the target is zero without a jump
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[8:1] != 8'd0) &&
                     (rsp_tdata[10] || rsp_tdata[26:11] == 16'd0))
      else $error("result fields inconsistent");

endmodule

bind brainfuck_execute_unit bfeu_checker u_bfeu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
